// ===== sv/lrud_pkg.sv =====
// Shared definitions for the LRU block cache directory.
// Holds default sizes, request and result codes, the controller state type and
// the command and status bundles; depends on nothing else.
`timescale 1ns / 1ps

package lrud_pkg;

    localparam int DEF_CACHE_ENTRIES   = 32;
    localparam int DEF_BLOCK_ADDR_BITS = 16;

    // Request codes carried in s_axis_tuser.
    localparam logic [1:0] MODE_ACCESS = 2'd0;
    localparam logic [1:0] MODE_MARK   = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    // Result codes carried in m_axis_tuser.
    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_MARK   = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted request
        logic exec;        // run an access or mark and load its result
        logic flush_init;  // restart the flush scan at rank zero
        logic flush_adv;   // step past a clean entry
        logic flush_emit;  // load a flush result and step on
    } lrud_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic scan_dirty;  // the entry at the scanned rank is dirty
        logic flush_none;  // no dirty entry anywhere
        logic flush_last;  // next flush result is the final one
    } lrud_status_t;

endpackage

// ===== sv/lrud_ctrl.sv =====
// Controller state machine for the LRU block cache directory.
// Uses lrud_pkg for the state type and the command and status bundles.
`timescale 1ns / 1ps

module lrud_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_mode,
    output logic                 s_ready,
    input  lrud_pkg::lrud_status_t status,
    output lrud_pkg::lrud_cmd_t    cmd
);
    import lrud_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode) inside
                        MODE_ACCESS, MODE_MARK: state_next = ST_EXEC;
                        MODE_FLUSH:             state_next = ST_FLUSH;
                        default:                state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EXEC: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (status.flush_none) begin
                    state_next = ST_IDLE;
                end else if (status.scan_dirty && status.out_free && status.flush_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // No beat is taken while reset is held.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready        = aresetn;
                cmd.capture    = s_valid && aresetn;
                cmd.flush_init = s_valid && aresetn && (s_mode == MODE_FLUSH);
            end
            ST_EXEC: begin
                cmd.exec = status.out_free;
            end
            ST_FLUSH: begin
                if (!status.flush_none) begin
                    cmd.flush_emit = status.scan_dirty && status.out_free;
                    cmd.flush_adv  = !status.scan_dirty;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/lrud_datapath.sv =====
// Datapath of the LRU block cache directory: entry tags, valid and dirty bits,
// recency ranks, counters, flush scan and the output register.
// Uses lrud_pkg for codes and the command and status bundles.
`timescale 1ns / 1ps

module lrud_datapath #(
    parameter int CACHE_ENTRIES   = lrud_pkg::DEF_CACHE_ENTRIES,
    parameter int BLOCK_ADDR_BITS = lrud_pkg::DEF_BLOCK_ADDR_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lrud_pkg::lrud_cmd_t                cmd,
    output lrud_pkg::lrud_status_t             status,
    input  logic [1:0]                         in_mode,
    input  logic [BLOCK_ADDR_BITS-1:0]         in_block,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         out_kind,
    output logic                               out_hit,
    output logic [$clog2(CACHE_ENTRIES)-1:0]   out_slot,
    output logic                               out_evicted,
    output logic [BLOCK_ADDR_BITS-1:0]         out_writeback_block,
    output logic                               out_fill_request,
    output logic                               out_last
);
    import lrud_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    // Directory state. Tags and ranks are only looked at while the entry is valid.
    logic [CACHE_ENTRIES-1:0]   valid_reg;
    logic [CACHE_ENTRIES-1:0]   dirty_reg;
    logic [BLOCK_ADDR_BITS-1:0] tag_reg  [CACHE_ENTRIES];
    logic [IDX_W-1:0]           rank_reg [CACHE_ENTRIES];
    logic [CNT_W-1:0]           occ_reg;
    logic [CNT_W-1:0]           dirty_cnt_reg;

    logic [1:0]                 req_mode_reg;
    logic [BLOCK_ADDR_BITS-1:0] req_blk_reg;

    logic [IDX_W-1:0]           scan_rank_reg;
    logic [CNT_W-1:0]           emitted_reg;

    logic                       out_valid_reg;
    logic [1:0]                 out_kind_reg;
    logic                       out_hit_reg;
    logic [IDX_W-1:0]           out_slot_reg;
    logic                       out_evicted_reg;
    logic [BLOCK_ADDR_BITS-1:0] out_wb_reg;
    logic                       out_fill_reg;
    logic                       out_last_reg;

    logic [CACHE_ENTRIES-1:0]   hit_vec;
    logic [CACHE_ENTRIES-1:0]   victim_vec;
    logic [CACHE_ENTRIES-1:0]   scan_vec;
    logic [IDX_W-1:0]           hit_idx;
    logic [IDX_W-1:0]           victim_idx;
    logic [IDX_W-1:0]           scan_idx;
    logic [IDX_W-1:0]           free_idx;
    logic [IDX_W-1:0]           hit_rank;
    logic                       hit_any;
    logic                       full;
    logic                       is_access;
    logic                       is_mark;
    logic [IDX_W-1:0]           access_slot;
    logic                       load_out;

    // Parallel match lines. Among valid entries the ranks form a permutation
    // and the tags are distinct, so each vector has at most one bit set.
    always_comb begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            hit_vec[i]    = valid_reg[i] && (tag_reg[i] == req_blk_reg);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == '0);
            scan_vec[i]   = valid_reg[i] && (rank_reg[i] == scan_rank_reg);
        end
    end

    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        scan_idx   = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (hit_vec[i])    hit_idx    = hit_idx    | IDX_W'(i);
            if (victim_vec[i]) victim_idx = victim_idx | IDX_W'(i);
            if (scan_vec[i])   scan_idx   = scan_idx   | IDX_W'(i);
        end
    end

    // Lowest-numbered free slot.
    always_comb begin
        free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) free_idx = IDX_W'(i);
        end
    end

    assign hit_any     = |hit_vec;
    assign hit_rank    = rank_reg[hit_idx];
    assign full        = (occ_reg == CNT_W'(CACHE_ENTRIES));
    assign is_access   = (req_mode_reg == MODE_ACCESS);
    assign is_mark     = (req_mode_reg == MODE_MARK);
    assign access_slot = hit_any ? hit_idx : (full ? victim_idx : free_idx);
    assign load_out    = cmd.exec || cmd.flush_emit;

    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.scan_dirty = |(scan_vec & dirty_reg);
    assign status.flush_none = (dirty_cnt_reg == '0);
    assign status.flush_last = ((emitted_reg + CNT_W'(1)) == dirty_cnt_reg);

    // Control state: valid and dirty bits, counters, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            dirty_reg     <= '0;
            occ_reg       <= '0;
            dirty_cnt_reg <= '0;
            scan_rank_reg <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec && is_access && !hit_any) begin
                if (full) begin
                    dirty_reg[victim_idx] <= 1'b0;
                    if (dirty_reg[victim_idx]) begin
                        dirty_cnt_reg <= dirty_cnt_reg - CNT_W'(1);
                    end
                end else begin
                    valid_reg[free_idx] <= 1'b1;
                    dirty_reg[free_idx] <= 1'b0;
                    occ_reg             <= occ_reg + CNT_W'(1);
                end
            end
            if (cmd.exec && is_mark && hit_any) begin
                dirty_reg[hit_idx] <= 1'b1;
                if (!dirty_reg[hit_idx]) begin
                    dirty_cnt_reg <= dirty_cnt_reg + CNT_W'(1);
                end
            end

            if (cmd.flush_init) begin
                scan_rank_reg <= '0;
                emitted_reg   <= '0;
            end else if (cmd.flush_adv || cmd.flush_emit) begin
                scan_rank_reg <= scan_rank_reg + IDX_W'(1);
                if (cmd.flush_emit) begin
                    emitted_reg <= emitted_reg + CNT_W'(1);
                end
            end

            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload state: request latch, tags, ranks and the result fields.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_mode_reg <= in_mode;
            req_blk_reg  <= in_block;
        end

        if (cmd.exec && is_access) begin
            if (hit_any) begin
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] > hit_rank)) begin
                        rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                    end
                end
                rank_reg[hit_idx] <= IDX_W'(occ_reg - CNT_W'(1));
            end else if (full) begin
                for (int i = 0; i < CACHE_ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] != '0)) begin
                        rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                    end
                end
                rank_reg[victim_idx] <= IDX_W'(CACHE_ENTRIES - 1);
                tag_reg[victim_idx]  <= req_blk_reg;
            end else begin
                rank_reg[free_idx] <= IDX_W'(occ_reg);
                tag_reg[free_idx]  <= req_blk_reg;
            end
        end

        if (cmd.exec) begin
            out_last_reg <= 1'b1;
            out_hit_reg  <= hit_any;
            if (is_access) begin
                out_kind_reg    <= KIND_ACCESS;
                out_slot_reg    <= access_slot;
                out_evicted_reg <= !hit_any && full;
                out_wb_reg      <= (!hit_any && full) ? tag_reg[victim_idx] : '0;
                out_fill_reg    <= !hit_any;
            end else begin
                out_kind_reg    <= KIND_MARK;
                out_slot_reg    <= hit_any ? hit_idx : '0;
                out_evicted_reg <= 1'b0;
                out_wb_reg      <= '0;
                out_fill_reg    <= 1'b0;
            end
        end else if (cmd.flush_emit) begin
            out_kind_reg    <= KIND_FLUSH;
            out_hit_reg     <= 1'b1;
            out_slot_reg    <= scan_idx;
            out_evicted_reg <= 1'b0;
            out_wb_reg      <= tag_reg[scan_idx];
            out_fill_reg    <= 1'b0;
            out_last_reg    <= status.flush_last;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_kind            = out_kind_reg;
    assign out_hit             = out_hit_reg;
    assign out_slot            = out_slot_reg;
    assign out_evicted         = out_evicted_reg;
    assign out_writeback_block = out_wb_reg;
    assign out_fill_request    = out_fill_reg;
    assign out_last            = out_last_reg;

endmodule

// ===== sv/lru_block_cache_directory.sv =====
// Top level of the LRU block cache directory: stream ports and field packing.
// Instantiates lrud_ctrl and lrud_datapath; uses lrud_pkg.
`timescale 1ns / 1ps

// This block is the directory of a fully associative write-back block cache
// with least-recently-used replacement. Each input beat is one request: an
// access looks up a block number and reports a hit, or a miss with a fill into
// the lowest free slot, evicting the least recent entry (always with a
// write-back) once every slot is in use; a mark sets the dirty bit of a present
// block and reports hit=0, slot=0 for an absent one; a flush emits one beat per
// dirty entry from oldest to newest, with tlast on the final one, and leaves
// the dirty bits set. A flush with no dirty entry and the unused request code
// produce no output beat. Requests are handled one at a time. An access or a
// mark is taken in the idle state and run in the execute state, in which all
// tags are compared in parallel and every rank is updated at once. A flush is
// taken in the idle state and then walks the recency ranks from rank zero up
// to the last dirty entry, one rank per cycle while no dirty entry waits for
// the output register; with nothing dirty there is no walk. The unused request
// code is dropped as its beat is taken. A result beat sits in an output
// register, so the next request is taken while it waits; while m_axis_tready
// is low and that register is full, a pending result waits in its state. No
// beat is taken while reset is held. After reset the directory is empty and
// ready at once; there is no clearing pass.
module lru_block_cache_directory #(
    parameter int CACHE_ENTRIES   = lrud_pkg::DEF_CACHE_ENTRIES,
    parameter int BLOCK_ADDR_BITS = lrud_pkg::DEF_BLOCK_ADDR_BITS
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0 up: block_number, then zero fill to a whole byte.
    input  logic [((BLOCK_ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Fields from bit 0 up: mode.
    input  logic [1:0] s_axis_tuser,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0 up: hit, slot, evicted, writeback_block, fill_request,
    // then zero fill to a whole byte.
    output logic [((3 + $clog2(CACHE_ENTRIES) + BLOCK_ADDR_BITS + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // Fields from bit 0 up: kind.
    output logic [1:0] m_axis_tuser,
    output logic       m_axis_tlast
);
    import lrud_pkg::*;

    localparam int IDX_W      = $clog2(CACHE_ENTRIES);
    localparam int OUT_DATA_W = ((3 + IDX_W + BLOCK_ADDR_BITS + 7) / 8) * 8;

    lrud_cmd_t    cmd;
    lrud_status_t status;

    logic                       out_hit;
    logic [IDX_W-1:0]           out_slot;
    logic                       out_evicted;
    logic [BLOCK_ADDR_BITS-1:0] out_wb;
    logic                       out_fill;

    lrud_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_mode  (s_axis_tuser),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lrud_datapath #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .BLOCK_ADDR_BITS (BLOCK_ADDR_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .in_mode             (s_axis_tuser),
        .in_block            (s_axis_tdata[BLOCK_ADDR_BITS-1:0]),
        .out_valid           (m_axis_tvalid),
        .out_ready           (m_axis_tready),
        .out_kind            (m_axis_tuser),
        .out_hit             (out_hit),
        .out_slot            (out_slot),
        .out_evicted         (out_evicted),
        .out_writeback_block (out_wb),
        .out_fill_request    (out_fill),
        .out_last            (m_axis_tlast)
    );

    // Pack the result fields, lowest first; the size cast adds the zero fill.
    assign m_axis_tdata = OUT_DATA_W'({out_fill, out_wb, out_evicted, out_slot, out_hit});

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for lru_block_cache_directory: directed and random requests with checking.
// Keeps its own LRU directory predictor in a small class; needs lrud_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import lrud_pkg::*;

    localparam int ENTRIES        = DEF_CACHE_ENTRIES;
    localparam int BLK_BITS       = DEF_BLOCK_ADDR_BITS;
    localparam int SLOT_BITS      = $clog2(ENTRIES);
    localparam int IN_W           = ((BLK_BITS + 7) / 8) * 8;
    localparam int OUT_W          = ((3 + SLOT_BITS + BLK_BITS + 7) / 8) * 8;
    localparam int RANDOM_REQUESTS = 400;
    localparam int POOL_SIZE      = 48;
    localparam int STALL_LIMIT    = 5000;
    localparam int TAIL_CYCLES    = 40;
    localparam int IDLE_PERCENT   = 28;

    // Request code that the block ignores.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic                 hit;
        logic [SLOT_BITS-1:0] slot;
        logic                 evicted;
        logic [BLK_BITS-1:0]  wb_block;
        logic                 fill;
        logic                 last;
    } dir_result_t;

    // Tracks the directory contents and the result beats each request must produce.
    class lru_result_tracker;
        logic                 valid [ENTRIES];
        logic                 dirty [ENTRIES];
        logic [BLK_BITS-1:0]  tag   [ENTRIES];
        logic [SLOT_BITS-1:0] rank  [ENTRIES];
        int                   occupied;
        dir_result_t          awaited_q [$];
        int errors, beats, hits, fills, evictions, flush_beats;

        function new();
            for (int i = 0; i < ENTRIES; i++) begin
                valid[i] = 1'b0;
                dirty[i] = 1'b0;
            end
            occupied = 0;
            errors = 0;
            beats = 0;
            hits = 0;
            fills = 0;
            evictions = 0;
            flush_beats = 0;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // Predicts the outcome of one accepted request and queues its result beats.
        function void note_request(logic [1:0] mode, logic [BLK_BITS-1:0] blk);
            int s;
            int i;
            int lvl;
            logic [SLOT_BITS-1:0] old_rank;
            dir_result_t r;
            dir_result_t held;
            bit have_held;

            s = -1;
            r = '0;
            r.last = 1'b1;
            have_held = 1'b0;
            held = '0;
            for (i = 0; i < ENTRIES; i++)
                if (s < 0 && valid[i] && tag[i] == blk)
                    s = i;

            case (mode)
                MODE_ACCESS: begin
                    r.kind = KIND_ACCESS;
                    if (s >= 0) begin
                        // Hit: everything more recent slides down one rank.
                        old_rank = rank[s];
                        for (i = 0; i < ENTRIES; i++)
                            if (valid[i] && rank[i] > old_rank)
                                rank[i] = rank[i] - 1'b1;
                        rank[s] = SLOT_BITS'(occupied - 1);
                        r.hit = 1'b1;
                        r.slot = SLOT_BITS'(s);
                        hits++;
                    end else if (occupied == ENTRIES) begin
                        // Full: the rank-zero entry goes, written back whether dirty or not.
                        for (i = 0; i < ENTRIES; i++)
                            if (s < 0 && valid[i] && rank[i] == '0)
                                s = i;
                        r.evicted = 1'b1;
                        r.wb_block = tag[s];
                        for (i = 0; i < ENTRIES; i++)
                            if (valid[i] && rank[i] != '0)
                                rank[i] = rank[i] - 1'b1;
                        tag[s] = blk;
                        dirty[s] = 1'b0;
                        rank[s] = SLOT_BITS'(ENTRIES - 1);
                        r.slot = SLOT_BITS'(s);
                        r.fill = 1'b1;
                        evictions++;
                        fills++;
                    end else begin
                        for (i = 0; i < ENTRIES; i++)
                            if (s < 0 && !valid[i])
                                s = i;
                        valid[s] = 1'b1;
                        tag[s] = blk;
                        dirty[s] = 1'b0;
                        rank[s] = SLOT_BITS'(occupied);
                        occupied++;
                        r.slot = SLOT_BITS'(s);
                        r.fill = 1'b1;
                        fills++;
                    end
                    awaited_q.push_back(r);
                end
                MODE_MARK: begin
                    r.kind = KIND_MARK;
                    if (s >= 0) begin
                        dirty[s] = 1'b1;
                        r.hit = 1'b1;
                        r.slot = SLOT_BITS'(s);
                    end
                    awaited_q.push_back(r);
                end
                MODE_FLUSH: begin
                    // Walk ranks oldest first; each dirty entry gives one beat, the final
                    // one carrying last. The beat is held back until we know if it is final.
                    for (lvl = 0; lvl < occupied; lvl++)
                        for (i = 0; i < ENTRIES; i++)
                            if (valid[i] && rank[i] == SLOT_BITS'(lvl) && dirty[i]) begin
                                if (have_held)
                                    awaited_q.push_back(held);
                                held = '0;
                                held.kind = KIND_FLUSH;
                                held.hit = 1'b1;
                                held.slot = SLOT_BITS'(i);
                                held.wb_block = tag[i];
                                have_held = 1'b1;
                            end
                    if (have_held) begin
                        held.last = 1'b1;
                        awaited_q.push_back(held);
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("[%0t] result beat %0d: %s", $time, beats, msg);
        endtask

        task check_beat(logic [1:0] kind, logic [OUT_W-1:0] data, logic last);
            dir_result_t got;
            dir_result_t want;

            beats++;
            got.kind = kind;
            got.hit = data[0];
            got.slot = data[SLOT_BITS:1];
            got.evicted = data[SLOT_BITS+1];
            got.wb_block = data[SLOT_BITS+1+BLK_BITS:SLOT_BITS+2];
            got.fill = data[SLOT_BITS+2+BLK_BITS];
            got.last = last;
            if (awaited_q.size() == 0) begin
                report_mismatch($sformatf("arrived with nothing expected (kind %0d)", kind));
            end else begin
                want = awaited_q.pop_front();
                if (want.kind == KIND_FLUSH)
                    flush_beats++;
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                if (got.hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", got.hit, want.hit));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
                if (got.evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0b, expected %0b",
                                              got.evicted, want.evicted));
                if (got.wb_block !== want.wb_block)
                    report_mismatch($sformatf("writeback block %h, expected %h",
                                              got.wb_block, want.wb_block));
                if (got.fill !== want.fill)
                    report_mismatch($sformatf("fill %0b, expected %0b", got.fill, want.fill));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
            end
        endtask
    endclass

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic [1:0]        s_axis_tuser  = MODE_ACCESS;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;

    lru_result_tracker tracker;
    bit                steady = 1'b0;
    int                idle_cycles = 0;
    int                requests = 0;
    logic [BLK_BITS-1:0] pool [POOL_SIZE];

    lru_block_cache_directory #(
        .CACHE_ENTRIES  (ENTRIES),
        .BLOCK_ADDR_BITS(BLK_BITS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // Result side: random back-pressure except during the steady stretch.
    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            tracker.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("** lru_block_cache_directory: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request, with random gaps beforehand, and waits until it is taken.
    task automatic send_request(input logic [1:0] mode, input logic [BLK_BITS-1:0] blk);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(blk);
        s_axis_tuser  <= mode;
        do
            @(posedge aclk);
        while (!s_axis_tready);
        tracker.note_request(mode, blk);
        requests++;
    endtask

    initial begin
        int k;
        int pick;
        int span;
        logic [1:0] mode;
        logic [BLK_BITS-1:0] blk;

        tracker = new();
        for (k = 0; k < POOL_SIZE; k++)
            pool[k] = BLK_BITS'($urandom);
        pool[0] = '0;
        pool[1] = '1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: empty-cache corner cases, extreme block numbers, every request.
        send_request(MODE_FLUSH, '0);           // nothing dirty, so no beat
        send_request(MODE_UNUSED, 16'h5a5a);    // ignored code
        send_request(MODE_MARK, '0);            // absent block
        send_request(MODE_ACCESS, '0);
        send_request(MODE_ACCESS, '1);
        send_request(MODE_ACCESS, '0);          // hit on the least recent entry
        send_request(MODE_MARK, '1);
        send_request(MODE_MARK, '0);
        send_request(MODE_FLUSH, 16'h1234);     // two write-backs, oldest first
        send_request(MODE_ACCESS, 16'haaaa);
        send_request(MODE_ACCESS, 16'h5555);
        send_request(MODE_UNUSED, '1);
        send_request(MODE_ACCESS, '1);          // hit on the least recent entry, below three others
        send_request(MODE_MARK, 16'h1234);
        send_request(MODE_MARK, 16'h5555);
        send_request(MODE_FLUSH, '1);           // dirty bits survive the earlier flush
        send_request(MODE_ACCESS, 16'haaaa);
        send_request(MODE_MARK, 16'haaaa);
        send_request(MODE_FLUSH, '0);

        // Random part: mostly accesses and marks on a small pool of blocks so that hits,
        // fills, evictions and dirty write-backs all happen; the pool width alternates
        // between fitting the cache and overflowing it, with some wide-range noise.
        k = 0;
        while (k < RANDOM_REQUESTS) begin
            steady = (k >= 150 && k < 260);
            span = ((k / 100) % 2 == 0) ? POOL_SIZE : 24;
            pick = $urandom_range(99);
            if (pick < 2)
                mode = MODE_UNUSED;
            else if (pick < 8)
                mode = MODE_FLUSH;
            else if (pick < 30)
                mode = MODE_MARK;
            else
                mode = MODE_ACCESS;
            if ($urandom_range(9) == 0)
                blk = BLK_BITS'($urandom);
            else
                blk = pool[$urandom_range(span - 1)];
            send_request(mode, blk);
            if (mode != MODE_UNUSED)
                k++;
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d result beats.", requests, tracker.beats);
        $display("Saw %0d hits, %0d fills, %0d evictions and %0d flush write-backs.",
                 tracker.hits, tracker.fills, tracker.evictions, tracker.flush_beats);
        if (tracker.errors == 0)
            $display("** lru_block_cache_directory: PASSED **");
        else
            $display("** lru_block_cache_directory: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lrud_pkg.sv
sv/lrud_ctrl.sv
sv/lrud_datapath.sv
sv/lru_block_cache_directory.sv
bench/testbench.sv
